### rtl/cpfp_pkg.sv
// cpfp_pkg: shared types, character codes and helpers for the position frame parser
// no dependencies; imported by every module of the block
package cpfp_pkg;

  localparam logic [7:0] START_CHAR  = 8'h3E;
  localparam logic [7:0] END_CHAR    = 8'h3B;
  localparam logic [7:0] OWN_DEFAULT = 8'h58;
  localparam int         SUM_W       = 6;
  localparam int         MIN_LEN     = 13;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  typedef struct packed {
    logic        frame_end;
    logic        frame_ok;
    logic [3:0]  match_now;
    logic        run_flag;
    logic [19:0] own_pos;
  } cpfp_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

### rtl/cpfp_frame_decode.sv
// cpfp_frame_decode: per-byte frame state, three-byte delay line, record decode,
// checksum check and commit of the record store; uses cpfp_pkg
module cpfp_frame_decode #(
  parameter int FRAME_BYTES = 128,
  parameter int MAX_ENTRIES = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic                               command,
  input  logic [7:0]                         rx_byte,
  input  logic [7:0]                         own_letter,
  output cpfp_pkg::cpfp_status_t             status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   entry_total,
  output logic [7:0]                         entry_letters [MAX_ENTRIES],
  output logic [19:0]                        entry_coords [MAX_ENTRIES]
);
  import cpfp_pkg::*;

  localparam int POS_W     = $clog2(FRAME_BYTES);
  localparam int CNT_W     = $clog2(MAX_ENTRIES+1);
  localparam int LAG       = 3;
  localparam int MATCH_POS = LAG + 1;
  localparam int HEAD_LAST = LAG + 5;
  localparam int REC_LAST  = 6;
  localparam int X_LAST    = 3;

  logic              is_open, is_open_next;
  logic [POS_W-1:0]  frame_pos, frame_pos_next;
  logic              frame_broken, frame_broken_next;
  logic [7:0]        byte_delay [LAG];
  logic [7:0]        byte_delay_next [LAG];
  logic [SUM_W-1:0]  running_sum, running_sum_next;
  logic [9:0]        field_accum, field_accum_next;
  logic              head_bad, head_bad_next;
  logic [3:0]        frame_match, frame_match_next;
  logic [CNT_W-1:0]  shadow_total, shadow_total_next;
  logic              rec_fail, rec_fail_next;
  logic              rec_bad, rec_bad_next;
  logic [7:0]        rec_letter, rec_letter_next;
  logic [9:0]        rec_x, rec_x_next;
  logic [2:0]        rec_off, rec_off_next;
  logic [7:0]        shadow_letters [MAX_ENTRIES];
  logic [19:0]       shadow_coords [MAX_ENTRIES];
  logic [CNT_W-1:0]  entry_total_next;
  logic [3:0]        match_now, match_now_next;
  logic [3:0]        match_before, match_before_next;
  logic              run_flag, run_flag_next;
  logic [19:0]       own_pos, own_pos_next;
  logic              end_next, ok_next;
  logic              frame_end, frame_ok;

  logic              wr_en;
  logic [CNT_W-1:0]  wr_slot;
  logic [19:0]       wr_coord;
  logic              commit;
  logic [7:0]        view_letters [MAX_ENTRIES];
  logic [19:0]       view_coords [MAX_ENTRIES];

  always_comb begin
    logic             do_append;
    logic             do_close;
    logic [POS_W-1:0] p;
    logic [7:0]       b;
    logic [13:0]      acc_mul;
    logic [SUM_W-1:0] chk;
    logic [6:0]       cks_val;
    logic             good;
    logic             own_hit;
    logic [19:0]      own_sel;

    is_open_next      = is_open;
    frame_pos_next    = frame_pos;
    frame_broken_next = frame_broken;
    for (int i = 0; i < LAG; i++) byte_delay_next[i] = byte_delay[i];
    running_sum_next  = running_sum;
    field_accum_next  = field_accum;
    head_bad_next     = head_bad;
    frame_match_next  = frame_match;
    shadow_total_next = shadow_total;
    rec_fail_next     = rec_fail;
    rec_bad_next      = rec_bad;
    rec_letter_next   = rec_letter;
    rec_x_next        = rec_x;
    rec_off_next      = rec_off;
    entry_total_next  = entry_total;
    match_now_next    = match_now;
    match_before_next = match_before;
    run_flag_next     = run_flag;
    own_pos_next      = own_pos;
    end_next          = 1'b0;
    ok_next           = 1'b0;
    wr_en             = 1'b0;
    wr_slot           = shadow_total;
    wr_coord          = 20'd0;
    commit            = 1'b0;
    do_append         = 1'b0;
    do_close          = 1'b0;
    b                 = byte_delay[0];
    acc_mul           = 14'd0;
    chk               = '0;
    cks_val           = 7'd0;
    good              = 1'b0;
    own_hit           = 1'b0;
    own_sel           = 20'd0;

    if (command == CMD_TIMEOUT) begin
      is_open_next   = 1'b0;
      frame_pos_next = '0;
    end else if (rx_byte == START_CHAR) begin
      is_open_next      = 1'b1;
      frame_broken_next = 1'b0;
      frame_pos_next    = '0;
      running_sum_next  = '0;
      field_accum_next  = '0;
      head_bad_next     = 1'b0;
      frame_match_next  = '0;
      shadow_total_next = '0;
      rec_fail_next     = 1'b0;
      rec_bad_next      = 1'b0;
      rec_letter_next   = '0;
      rec_x_next        = '0;
      rec_off_next      = '0;
      do_append         = 1'b1;
    end else if (!is_open) begin
      is_open_next = 1'b0;
    end else if (frame_pos >= POS_W'(FRAME_BYTES-1)) begin
      is_open_next   = 1'b0;
      frame_pos_next = '0;
    end else if (rx_byte == END_CHAR) begin
      do_append = 1'b1;
      do_close  = 1'b1;
    end else begin
      if (rx_byte == 8'd0) frame_broken_next = 1'b1;
      do_append = 1'b1;
    end

    // decode the byte leaving the delay line
    p = frame_pos_next;
    wr_slot = shadow_total_next;
    if (do_append && p >= POS_W'(LAG)) begin
      running_sum_next = running_sum_next + b[SUM_W-1:0];
      if (p == POS_W'(LAG)) begin
        head_bad_next = head_bad_next;
      end else if (p <= POS_W'(HEAD_LAST)) begin
        if (!is_digit(b)) head_bad_next = 1'b1;
        else if (p == POS_W'(MATCH_POS)) frame_match_next = b[3:0];
      end else begin
        rec_off_next = (rec_off_next == 3'(REC_LAST)) ? 3'd0 : rec_off_next + 3'd1;
        if (!rec_fail_next && shadow_total_next < CNT_W'(MAX_ENTRIES)) begin
          if (rec_off == 3'd0 || p == POS_W'(HEAD_LAST+1)) begin
            rec_letter_next  = b;
            rec_bad_next     = 1'b0;
            field_accum_next = '0;
          end else begin
            if (is_digit(b)) begin
              acc_mul = {1'b0, field_accum_next, 3'b000} + {3'b000, field_accum_next, 1'b0};
              acc_mul = acc_mul + {10'd0, b[3:0]};
              field_accum_next = acc_mul[9:0];
            end else begin
              rec_bad_next = 1'b1;
            end
            if (rec_off == 3'(X_LAST)) begin
              rec_x_next       = field_accum_next;
              field_accum_next = '0;
            end else if (rec_off == 3'(REC_LAST)) begin
              if (rec_bad_next) begin
                rec_fail_next = 1'b1;
              end else begin
                wr_en             = 1'b1;
                wr_coord          = {rec_x_next, field_accum_next};
                shadow_total_next = shadow_total_next + CNT_W'(1);
              end
            end
          end
        end
      end
    end
    if (do_append) begin
      for (int i = 0; i < LAG-1; i++) byte_delay_next[i] = byte_delay[i+1];
      byte_delay_next[LAG-1] = rx_byte;
      frame_pos_next = p + POS_W'(1);
    end

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      view_letters[i] = (wr_en && wr_slot == CNT_W'(i)) ? rec_letter_next : shadow_letters[i];
      view_coords[i]  = (wr_en && wr_slot == CNT_W'(i)) ? wr_coord : shadow_coords[i];
    end

    // checksum and commit
    chk     = running_sum_next + END_CHAR[SUM_W-1:0];
    cks_val = {byte_delay_next[0][3:0], 3'b000} + {2'b00, byte_delay_next[0][3:0], 1'b0}
              + {3'b000, byte_delay_next[1][3:0]};
    good = !frame_broken_next && (frame_pos_next >= POS_W'(MIN_LEN))
           && is_digit(byte_delay_next[0]) && is_digit(byte_delay_next[1])
           && ({1'b0, chk} == cks_val) && !head_bad_next;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (CNT_W'(i) < shadow_total_next && view_letters[i] == own_letter) begin
        own_hit = 1'b1;
        own_sel = view_coords[i];
      end
    end
    if (do_close) begin
      end_next = 1'b1;
      if (good) begin
        commit           = 1'b1;
        match_now_next   = frame_match_next;
        entry_total_next = shadow_total_next;
        if (own_hit) own_pos_next = own_sel;
        if (!rec_fail_next && shadow_total_next != '0) begin
          ok_next = 1'b1;
          if (frame_match_next == 4'd1 && match_before == 4'd0) run_flag_next = 1'b1;
          match_before_next = frame_match_next;
        end
      end
      is_open_next   = 1'b0;
      frame_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_open      <= 1'b0;
      frame_pos    <= '0;
      frame_broken <= 1'b0;
      for (int i = 0; i < LAG; i++) byte_delay[i] <= '0;
      running_sum  <= '0;
      field_accum  <= '0;
      head_bad     <= 1'b0;
      frame_match  <= '0;
      shadow_total <= '0;
      rec_fail     <= 1'b0;
      rec_bad      <= 1'b0;
      rec_letter   <= '0;
      rec_x        <= '0;
      rec_off      <= '0;
      entry_total  <= '0;
      match_now    <= '0;
      match_before <= '0;
      run_flag     <= 1'b0;
      own_pos      <= '0;
      frame_end    <= 1'b0;
      frame_ok     <= 1'b0;
    end else if (step) begin
      is_open      <= is_open_next;
      frame_pos    <= frame_pos_next;
      frame_broken <= frame_broken_next;
      for (int i = 0; i < LAG; i++) byte_delay[i] <= byte_delay_next[i];
      running_sum  <= running_sum_next;
      field_accum  <= field_accum_next;
      head_bad     <= head_bad_next;
      frame_match  <= frame_match_next;
      shadow_total <= shadow_total_next;
      rec_fail     <= rec_fail_next;
      rec_bad      <= rec_bad_next;
      rec_letter   <= rec_letter_next;
      rec_x        <= rec_x_next;
      rec_off      <= rec_off_next;
      entry_total  <= entry_total_next;
      match_now    <= match_now_next;
      match_before <= match_before_next;
      run_flag     <= run_flag_next;
      own_pos      <= own_pos_next;
      frame_end    <= end_next;
      frame_ok     <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        shadow_letters[i] <= view_letters[i];
        shadow_coords[i]  <= view_coords[i];
        if (commit) begin
          entry_letters[i] <= view_letters[i];
          entry_coords[i]  <= view_coords[i];
        end
      end
    end
  end

  assign status.frame_end = frame_end;
  assign status.frame_ok  = frame_ok;
  assign status.match_now = match_now;
  assign status.run_flag  = run_flag;
  assign status.own_pos   = own_pos;

  a_shadow_bound: assert property (@(posedge clk) disable iff (rst)
    shadow_total <= CNT_W'(MAX_ENTRIES) && entry_total <= CNT_W'(MAX_ENTRIES))
    else $error("record count beyond store depth");

  a_run_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(run_flag) && !$past(rst) |-> run_flag)
    else $error("running flag cleared");

  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    status.frame_ok |-> status.frame_end)
    else $error("frame ok without frame end");

endmodule

### rtl/cpfp_entry_scan.sv
// cpfp_entry_scan: result register; finds the first stored record not under the own letter
// uses cpfp_pkg; fed by cpfp_frame_decode
module cpfp_entry_scan #(
  parameter int MAX_ENTRIES = 10
) (
  input  logic                             clk,
  input  logic                             load,
  input  cpfp_pkg::cpfp_status_t           status,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0] entry_total,
  input  logic [7:0]                       entry_letters [MAX_ENTRIES],
  input  logic [19:0]                      entry_coords [MAX_ENTRIES],
  input  logic [7:0]                       own_letter,
  output logic                             frame_end,
  output logic                             frame_ok,
  output logic [3:0]                       match_bit,
  output logic                             running,
  output logic [9:0]                       own_x,
  output logic [9:0]                       own_y,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
  output logic                             other_valid,
  output logic [9:0]                       other_x,
  output logic [9:0]                       other_y
);
  import cpfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES+1);

  logic        hit;
  logic [19:0] sel;

  // descending pass so the lowest matching slot wins
  always_comb begin
    hit = 1'b0;
    sel = 20'd0;
    for (int i = MAX_ENTRIES-1; i >= 0; i--) begin
      if (CNT_W'(i) < entry_total && entry_letters[i] != own_letter) begin
        hit = 1'b1;
        sel = entry_coords[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_end   <= status.frame_end;
      frame_ok    <= status.frame_ok;
      match_bit   <= status.match_now;
      running     <= status.run_flag;
      own_x       <= status.own_pos[19:10];
      own_y       <= status.own_pos[9:0];
      entry_count <= entry_total;
      other_valid <= hit;
      other_x     <= sel[19:10];
      other_y     <= sel[9:0];
    end
  end

endmodule

### rtl/checksummed_position_frame_parser_unit.sv
// checksummed_position_frame_parser_unit: top level with input, decode and result stages
// uses cpfp_pkg, cpfp_frame_decode and cpfp_entry_scan
// The unit takes one beat per clock while in_ready is high: a received byte or a silence
// timeout. Each beat gives exactly one result beat: the input register loads at the accepting
// edge, then the frame state updates, then the result register loads. The three stages
// fill independently, so input keeps flowing while up to two results wait on a stalled
// output. own_letter is written through the
// cfg channel, which is always ready, and should be changed only while no beat is in flight.
module checksummed_position_frame_parser_unit #(
  parameter int FRAME_BYTES = 128,
  parameter int MAX_ENTRIES = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             frame_end,
  output logic                             frame_ok,
  output logic [3:0]                       match_bit,
  output logic                             running,
  output logic [9:0]                       own_x,
  output logic [9:0]                       own_y,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
  output logic                             other_valid,
  output logic [9:0]                       other_x,
  output logic [9:0]                       other_y,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [7:0]                       cfg_data
);
  import cpfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES+1);

  logic             s1_valid;
  logic             s1_command;
  logic [7:0]       s1_byte;
  logic             s2_valid;
  logic             load_o, load_2, load_1;
  logic [7:0]       own_letter;
  cpfp_status_t     status;
  logic [CNT_W-1:0] entry_total;
  logic [7:0]       entry_letters [MAX_ENTRIES];
  logic [19:0]      entry_coords [MAX_ENTRIES];

  assign load_o    = !out_valid || out_ready;
  assign load_2    = !s2_valid || load_o;
  assign load_1    = !s1_valid || load_2;
  assign in_ready  = load_1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
      own_letter <= OWN_DEFAULT;
    end else begin
      if (load_1) s1_valid <= in_valid;
      if (load_2) s2_valid <= s1_valid;
      if (load_o) out_valid <= s2_valid;
      if (cfg_valid) own_letter <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && load_1) begin
      s1_command <= command;
      s1_byte    <= rx_byte;
    end
  end

  cpfp_frame_decode #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_valid && load_2),
    .command       (s1_command),
    .rx_byte       (s1_byte),
    .own_letter    (own_letter),
    .status        (status),
    .entry_total   (entry_total),
    .entry_letters (entry_letters),
    .entry_coords  (entry_coords)
  );

  cpfp_entry_scan #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_scan (
    .clk           (clk),
    .load          (s2_valid && load_o),
    .status        (status),
    .entry_total   (entry_total),
    .entry_letters (entry_letters),
    .entry_coords  (entry_coords),
    .own_letter    (own_letter),
    .frame_end     (frame_end),
    .frame_ok      (frame_ok),
    .match_bit     (match_bit),
    .running       (running),
    .own_x         (own_x),
    .own_y         (own_y),
    .entry_count   (entry_count),
    .other_valid   (other_valid),
    .other_x       (other_x),
    .other_y       (other_y)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted beat lost at input stage");

  a_ok_with_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> frame_end)
    else $error("frame ok reported without frame end");

endmodule

### sim/checksummed_position_frame_parser_unit_tb.sv
// checksummed_position_frame_parser_unit_tb: self-checking bench for the position frame parser
// drives byte and timeout beats with random gaps and stalls, predicts every result beat
// depends on cpfp_pkg and checksummed_position_frame_parser_unit
module checksummed_position_frame_parser_unit_tb;
  import cpfp_pkg::*;

  localparam int FRAME_BYTES = 128;
  localparam int MAX_ENTRIES = 10;
  localparam int SUM_MOD = 1 << SUM_W;
  localparam bit [7:0] ASCII_0 = "0";
  localparam bit [7:0] CH_A = "A";
  localparam bit [7:0] CH_Z = "Z";
  localparam bit [7:0] NUL_CHAR = 8'h00;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum int {SUM_GOOD, SUM_WRONG, SUM_JUNK} sum_kind_e;
  typedef enum int {
    FLAW_NONE, FLAW_RECORD_DIGIT, FLAW_HEADER_DIGIT, FLAW_TRAILER,
    FLAW_SUM_WRONG, FLAW_SUM_JUNK, FLAW_NUL, FLAW_TIMEOUT, FLAW_RESTART
  } flaw_e;

  typedef struct packed {
    bit       frame_end;
    bit       frame_ok;
    bit [3:0] match;
    bit       running;
    bit [9:0] own_x;
    bit [9:0] own_y;
    bit [3:0] entries;
    bit       other_v;
    bit [9:0] other_x;
    bit [9:0] other_y;
  } status_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic command;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic frame_end;
  logic frame_ok;
  logic [3:0] match_bit;
  logic running;
  logic [9:0] own_x;
  logic [9:0] own_y;
  logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count;
  logic other_valid;
  logic [9:0] other_x;
  logic [9:0] other_y;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_data;

  checksummed_position_frame_parser_unit #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (.*);

  // parser image
  bit [7:0]  letter_cfg = OWN_DEFAULT;
  bit        in_frame = 0;
  int        frame_len = 0;
  bit        frame_nul = 0;
  bit [7:0]  lag [3];
  bit [SUM_W-1:0] sum6 = 0;
  bit [9:0]  accum = 0;
  bit        hdr_bad = 0;
  bit [3:0]  pend_match = 0;
  int        pend_count = 0;
  bit        rec_failed = 0;
  bit        rec_baddig = 0;
  bit [7:0]  rec_ltr = 0;
  bit [9:0]  rec_xval = 0;
  bit [7:0]  pend_letters [MAX_ENTRIES];
  bit [19:0] pend_coords [MAX_ENTRIES];
  bit [7:0]  kept_letters [MAX_ENTRIES];
  bit [19:0] kept_coords [MAX_ENTRIES];
  int        kept_count = 0;
  bit [3:0]  match_cur = 0;
  bit [3:0]  match_prev = 0;
  bit        run_latched = 0;
  bit [19:0] own_xy = 0;

  status_t expected_status [$];
  bit [7:0] body [$];
  bit calm = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int results_checked = 0;
  int busy_beats = 0;
  int frames_closed = 0;
  int frames_good = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("checksummed_position_frame_parser_unit_tb: errors");
    $finish;
  end

  function automatic bit dec_ok(bit [7:0] b);
    return b >= ASCII_0 && b <= ASCII_0 + 9;
  endfunction

  // a byte leaves the three-byte lag line and is decoded at its frame position
  function automatic void shift_in(bit [7:0] b);
    bit [7:0] aged;
    int q;
    int off;
    if (frame_len >= 3) begin
      aged = lag[0];
      q = frame_len - 3;
      sum6 = sum6 + aged;
      if (q >= 1 && q <= 5) begin
        if (!dec_ok(aged)) hdr_bad = 1;
        else if (q == 1) pend_match = aged - ASCII_0;
      end else if (q >= 6 && !rec_failed && pend_count < MAX_ENTRIES) begin
        off = (q - 6) % 7;
        if (off == 0) begin
          rec_ltr = aged;
          rec_baddig = 0;
          accum = 0;
        end else begin
          if (dec_ok(aged)) accum = accum * 10 + (aged - ASCII_0);
          else rec_baddig = 1;
          if (off == 3) begin
            rec_xval = accum;
            accum = 0;
          end else if (off == 6) begin
            if (rec_baddig) begin
              rec_failed = 1;
            end else begin
              pend_letters[pend_count] = rec_ltr;
              pend_coords[pend_count] = {rec_xval, accum};
              pend_count++;
            end
          end
        end
      end
    end
    lag[0] = lag[1];
    lag[1] = lag[2];
    lag[2] = b;
    frame_len++;
  endfunction

  function automatic status_t predict_beat(bit cmd, bit [7:0] b);
    status_t r;
    int want_sum;
    int i;
    r = '0;
    if (cmd == CMD_TIMEOUT) begin
      busy_beats++;
      in_frame = 0;
      frame_len = 0;
    end else if (b == START_CHAR) begin
      busy_beats++;
      in_frame = 1;
      frame_nul = 0;
      frame_len = 0;
      sum6 = 0;
      accum = 0;
      hdr_bad = 0;
      pend_match = 0;
      pend_count = 0;
      rec_failed = 0;
      rec_baddig = 0;
      rec_ltr = 0;
      rec_xval = 0;
      shift_in(b);
    end else if (in_frame) begin
      busy_beats++;
      if (frame_len >= FRAME_BYTES - 1) begin
        in_frame = 0;
        frame_len = 0;
      end else if (b == END_CHAR) begin
        shift_in(b);
        r.frame_end = 1;
        frames_closed++;
        want_sum = (sum6 + END_CHAR) % SUM_MOD;
        if (!frame_nul && frame_len >= MIN_LEN && dec_ok(lag[0]) && dec_ok(lag[1]) &&
            want_sum == (lag[0] - ASCII_0) * 10 + (lag[1] - ASCII_0) && !hdr_bad) begin
          match_cur = pend_match;
          kept_count = pend_count;
          for (i = 0; i < pend_count; i++) begin
            kept_letters[i] = pend_letters[i];
            kept_coords[i] = pend_coords[i];
            if (pend_letters[i] == letter_cfg) own_xy = pend_coords[i];
          end
          if (!rec_failed && pend_count != 0) begin
            r.frame_ok = 1;
            frames_good++;
            if (match_cur == 1 && match_prev == 0) run_latched = 1;
            match_prev = match_cur;
          end
        end
        in_frame = 0;
        frame_len = 0;
      end else begin
        if (b == NUL_CHAR) frame_nul = 1;
        shift_in(b);
      end
    end
    r.match = match_cur;
    r.running = run_latched;
    r.own_x = own_xy[19:10];
    r.own_y = own_xy[9:0];
    r.entries = kept_count;
    for (i = 0; i < kept_count; i++) begin
      if (kept_letters[i] != letter_cfg) begin
        r.other_v = 1;
        r.other_x = kept_coords[i][19:10];
        r.other_y = kept_coords[i][9:0];
        break;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [9:0] got, logic [9:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    status_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        check_field("frame_end", frame_end, want.frame_end);
        check_field("frame_ok", frame_ok, want.frame_ok);
        check_field("match_bit", match_bit, want.match);
        check_field("running", running, want.running);
        check_field("own_x", own_x, want.own_x);
        check_field("own_y", own_y, want.own_y);
        check_field("entry_count", entry_count, want.entries);
        check_field("other_valid", other_valid, want.other_v);
        check_field("other_x", other_x, want.other_x);
        check_field("other_y", other_y, want.other_y);
      end
    end
  end

  // result side: random stall per beat, or a long hold when asked
  initial begin : result_sink
    int stall;
    out_ready <= 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_beat(bit cmd, bit [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_status.push_back(predict_beat(cmd, b));
  endtask

  task automatic settle();
    in_valid <= 0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_own_letter(bit [7:0] v);
    settle();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    letter_cfg = v;
    cfg_valid <= 0;
  endtask

  function automatic bit [7:0] junk_byte();
    bit [7:0] b;
    do b = $urandom_range(1, 255);
    while (dec_ok(b) || b == START_CHAR || b == END_CHAR);
    return b;
  endfunction

  function automatic bit [7:0] pick_letter();
    case ($urandom_range(0, 4))
      0, 1: return letter_cfg;
      2: return 8'($urandom_range(CH_A, CH_Z));
      default: return junk_byte();
    endcase
  endfunction

  function automatic void begin_body(bit [3:0] m);
    body.delete();
    body.push_back(ASCII_0 + m);
    repeat (4) body.push_back(ASCII_0 + $urandom_range(0, 9));
  endfunction

  function automatic void add_record(bit [7:0] letter, int x, int y);
    body.push_back(letter);
    body.push_back(ASCII_0 + x / 100);
    body.push_back(ASCII_0 + (x / 10) % 10);
    body.push_back(ASCII_0 + x % 10);
    body.push_back(ASCII_0 + y / 100);
    body.push_back(ASCII_0 + (y / 10) % 10);
    body.push_back(ASCII_0 + y % 10);
  endfunction

  function automatic void pad_body(int n);
    while (body.size() < n) body.push_back(ASCII_0 + $urandom_range(0, 9));
  endfunction

  // opens a frame and sends only the first k body bytes
  task automatic send_part(int k);
    int i;
    send_beat(CMD_BYTE, START_CHAR);
    for (i = 0; i < k && i < body.size(); i++) send_beat(CMD_BYTE, body[i]);
  endtask

  task automatic send_frame(sum_kind_e kind);
    bit [SUM_W-1:0] s;
    int chk;
    bit [7:0] tens;
    bit [7:0] ones;
    s = START_CHAR;
    foreach (body[i]) s = s + body[i];
    chk = (s + END_CHAR) % SUM_MOD;
    if (kind == SUM_WRONG) chk = (chk + $urandom_range(1, 99)) % 100;
    tens = ASCII_0 + chk / 10;
    ones = ASCII_0 + chk % 10;
    if (kind == SUM_JUNK) begin
      if ($urandom_range(0, 1)) tens = junk_byte();
      else ones = junk_byte();
    end
    send_beat(CMD_BYTE, START_CHAR);
    foreach (body[i]) send_beat(CMD_BYTE, body[i]);
    send_beat(CMD_BYTE, tens);
    send_beat(CMD_BYTE, ones);
    send_beat(CMD_BYTE, END_CHAR);
  endtask

  task automatic test_idle_bytes();
    send_beat(CMD_BYTE, NUL_CHAR);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, END_CHAR);
    send_beat(CMD_TIMEOUT, 8'hA5);
    send_beat(CMD_TIMEOUT, START_CHAR);
  endtask

  task automatic test_good_frames();
    begin_body(0);
    add_record(letter_cfg, 999, 999);
    add_record("B", 0, 0);
    send_frame(SUM_GOOD);
    // match digit steps 0 to 1
    begin_body(1);
    add_record("C", 512, 7);
    send_frame(SUM_GOOD);
    // more records than the store holds
    begin_body(9);
    repeat (MAX_ENTRIES + 1) add_record(pick_letter(), $urandom_range(0, 999),
                                        $urandom_range(0, 999));
    send_frame(SUM_GOOD);
  endtask

  task automatic test_flawed_frames();
    // bad digit in second record, first still committed
    begin_body(2);
    add_record("D", 123, 456);
    add_record(letter_cfg, 1, 2);
    add_record("F", 3, 4);
    body[5 + 7 + 2] = junk_byte();
    send_frame(SUM_GOOD);
    // header and trailing bytes, no complete record
    begin_body(3);
    add_record("Q", 12, 0);
    void'(body.pop_back());
    send_frame(SUM_GOOD);
    begin_body(4);
    add_record("G", 44, 55);
    send_frame(SUM_WRONG);
    begin_body(4);
    add_record("G", 44, 55);
    send_frame(SUM_JUNK);
    // bad header digit
    begin_body(5);
    body[3] = junk_byte();
    add_record("H", 9, 9);
    send_frame(SUM_GOOD);
    // short frame
    body.delete();
    body.push_back(ASCII_0 + 1);
    send_frame(SUM_GOOD);
    // nul byte inside a record
    begin_body(6);
    add_record(letter_cfg, 300, 301);
    body[7] = NUL_CHAR;
    send_frame(SUM_GOOD);
    // start char restarts an open frame
    begin_body(7);
    add_record("J", 70, 80);
    send_part(9);
    send_frame(SUM_GOOD);
    // silence drops a partial frame
    send_part(10);
    send_beat(CMD_TIMEOUT, NUL_CHAR);
    send_beat(CMD_BYTE, END_CHAR);
  endtask

  task automatic test_frame_length();
    // longest frame that still closes
    begin_body(1);
    repeat (MAX_ENTRIES) add_record(pick_letter(), $urandom_range(0, 999),
                                    $urandom_range(0, 999));
    pad_body(FRAME_BYTES - 5);
    send_frame(SUM_GOOD);
    // end char arrives one byte too late
    begin_body(0);
    add_record(letter_cfg, 5, 6);
    pad_body(FRAME_BYTES - 4);
    send_frame(SUM_GOOD);
    // overflow on a digit, the rest is ignored
    begin_body(0);
    pad_body(FRAME_BYTES + 2);
    send_part(FRAME_BYTES + 2);
    send_beat(CMD_BYTE, END_CHAR);
  endtask

  task automatic test_own_letter();
    set_own_letter(8'h00);
    begin_body(1);
    add_record("A", 10, 20);
    add_record(8'h00, 30, 40);
    send_frame(SUM_GOOD);
    set_own_letter(8'hFF);
    begin_body(1);
    add_record("K", 111, 222);
    add_record(8'hFF, 333, 444);
    send_frame(SUM_GOOD);
    set_own_letter("K");
    begin_body(2);
    add_record("K", 555, 666);
    add_record(8'hFF, 777, 888);
    send_frame(SUM_GOOD);
    set_own_letter(OWN_DEFAULT);
    send_beat(CMD_BYTE, NUL_CHAR);
  endtask

  task automatic test_backpressure();
    settle();
    calm = 1;
    hold_cycles = 150;
    begin_body(1);
    repeat (3) add_record(pick_letter(), $urandom_range(0, 999), $urandom_range(0, 999));
    send_frame(SUM_GOOD);
    settle();
    calm = 0;
  endtask

  task automatic send_random_frame();
    int nrec;
    int roll;
    bit [3:0] m;
    flaw_e flaw;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4))
        send_beat($urandom_range(0, 15) == 0 ? CMD_TIMEOUT : CMD_BYTE,
                  8'($urandom_range(0, 255)));
    m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 1);
    nrec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
    begin_body(m);
    repeat (nrec) add_record(pick_letter(), $urandom_range(0, 999), $urandom_range(0, 999));
    roll = $urandom_range(0, 19);
    flaw = (roll < 12) ? FLAW_NONE : flaw_e'(roll - 11);
    case (flaw)
      FLAW_RECORD_DIGIT: begin
        if (nrec > 0)
          body[5 + 7 * $urandom_range(0, nrec - 1) + $urandom_range(1, 6)] = junk_byte();
      end
      FLAW_HEADER_DIGIT: body[$urandom_range(0, 4)] = junk_byte();
      FLAW_TRAILER: begin
        repeat ($urandom_range(1, 9))
          body.push_back($urandom_range(0, 1) ? junk_byte() : ASCII_0 + $urandom_range(0, 9));
      end
      FLAW_NUL: body[$urandom_range(0, body.size() - 1)] = NUL_CHAR;
      FLAW_TIMEOUT, FLAW_RESTART: send_part($urandom_range(0, body.size() - 1));
      default: ;
    endcase
    if (flaw == FLAW_TIMEOUT) send_beat(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
    send_frame(flaw == FLAW_SUM_WRONG ? SUM_WRONG :
               flaw == FLAW_SUM_JUNK ? SUM_JUNK : SUM_GOOD);
  endtask

  task automatic test_random_traffic(int target);
    int stop;
    int phase;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_own_letter(OWN_DEFAULT);
        1: set_own_letter(8'($urandom_range(CH_A, CH_Z)));
        default: set_own_letter(8'($urandom_range(128, 255)));
      endcase
      stop = busy_beats + target / 3;
      while (busy_beats < stop) begin
        // no idling on either side for part of the middle phase
        calm = (phase == 1) && (busy_beats < stop - target / 6);
        send_random_frame();
      end
      calm = 0;
    end
  endtask

  initial begin : main
    int waited;
    rst <= 1;
    in_valid <= 0;
    command <= CMD_BYTE;
    rx_byte <= 8'h00;
    cfg_valid <= 0;
    cfg_data <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_idle_bytes();
    test_good_frames();
    test_flawed_frames();
    test_frame_length();
    test_own_letter();
    test_backpressure();
    test_random_traffic(1150);
    in_valid <= 0;
    waited = 0;
    while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", expected_status.size()));
    $display("summary: %0d beats checked, %0d frames closed, %0d parsed clean, %0d mismatches",
             results_checked, frames_closed, frames_good, mismatches);
    if (mismatches == 0) begin
      $display("checksummed_position_frame_parser_unit_tb: clean");
    end else begin
      $display("checksummed_position_frame_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule
